FILE: rtl/fcc_pkg.sv
// Package for the FAT cluster chain engine: field widths, register indexes,
// codes, thresholds and the request and response types of the shared divider.
// Depends on nothing; fcc_if, fcc_div and the top level use it, fcc_store does not.
package fcc_pkg;

  // Default size of the byte store that holds the first FAT copy.
  localparam int unsigned FAT_STORE_BYTES_DEF = 65536;
  // Bytes in one directory entry.
  localparam int unsigned DIR_ENTRY_BYTES = 32;

  // Cluster count thresholds that separate the FAT types.
  localparam logic [31:0] FAT12_MAX_CLUSTERS = 32'd4085;
  localparam logic [31:0] FAT16_MAX_CLUSTERS = 32'd65525;

  // End-of-chain and bad-cluster thresholds, one for each FAT type.
  localparam logic [31:0] EOC_FAT12 = 32'h0000_0FF7;
  localparam logic [31:0] EOC_FAT16 = 32'h0000_FFF7;
  localparam logic [31:0] EOC_FAT32 = 32'h0FFF_FFF7;
  localparam logic [31:0] FAT12_ENTRY_MASK = 32'h0000_0FFF;

  // Register reset values.
  localparam logic [12:0] BPS_RST = 13'd512;
  localparam logic [7:0]  SPC_RST = 8'd1;
  localparam logic [15:0] RS_RST  = 16'd1;
  localparam logic [2:0]  NF_RST  = 3'd2;
  localparam logic [23:0] SPF_RST = 24'd9;
  localparam logic [15:0] RDE_RST = 16'd224;
  localparam logic [31:0] TS_RST  = 32'd2880;
  localparam logic [27:0] RC_RST  = 28'd2;

  // Channel field widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CLUSTER_W  = 28;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TYPE_W     = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYTES_PER_SECTOR    = 3'd0,
    REG_SECTORS_PER_CLUSTER = 3'd1,
    REG_RESERVED_SECTORS    = 3'd2,
    REG_NUMBER_OF_FATS      = 3'd3,
    REG_SECTORS_PER_FAT     = 3'd4,
    REG_ROOT_DIR_ENTRIES    = 3'd5,
    REG_TOTAL_SECTORS       = 3'd6,
    REG_ROOT_CLUSTER        = 3'd7
  } cfg_idx_e;

  // Operation codes of an input beat.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // FAT type codes.
  typedef enum logic [TYPE_W-1:0] {
    FAT12 = 2'd0,
    FAT16 = 2'd1,
    FAT32 = 2'd2
  } fat_type_e;

  // Shared divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/fcc_if.sv
// Channel interfaces of the FAT cluster chain engine: configuration writes,
// input beats and result beats. Depends on fcc_pkg for the field widths.
interface fcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fcc_pkg::CFG_IDX_W-1:0]  index;
  logic [fcc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface fcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [fcc_pkg::MODE_W-1:0]    mode;
  logic [fcc_pkg::ADDR_W-1:0]    fat_address;
  logic [fcc_pkg::BYTE_W-1:0]    fat_byte;
  logic [fcc_pkg::CLUSTER_W-1:0] cluster;
  modport source (output valid, mode, fat_address, fat_byte, cluster, input ready);
  modport sink   (input valid, mode, fat_address, fat_byte, cluster, output ready);
endinterface

interface fcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [fcc_pkg::WORD_W-1:0]    next_cluster;
  logic [fcc_pkg::WORD_W-1:0]    cluster_sector;
  logic                          end_of_chain;
  logic [fcc_pkg::CLUSTER_W-1:0] free_cluster;
  logic [fcc_pkg::TYPE_W-1:0]    fat_type;
  logic                          status;
  modport source (output valid, next_cluster, cluster_sector, end_of_chain,
                  free_cluster, fat_type, status, input ready);
  modport sink   (input valid, next_cluster, cluster_sector, end_of_chain,
                  free_cluster, fat_type, status, output ready);
endinterface

FILE: rtl/fcc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on fcc_pkg for the request and response types.
module fcc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcc_pkg::div_req_t req_i,
  output fcc_pkg::div_rsp_t rsp_o
);
  import fcc_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_sh;

  // One shift and trial subtract per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q[31:0], quo_q[31]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: rtl/fcc_store.sv
// Byte store for the first FAT copy: one write port and one read port with
// registered read data. Depends on nothing outside itself.
module fcc_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and ready in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fat_cluster_chain_engine_top.sv
// Top level of the FAT cluster chain engine: registers, sequencer, byte store
// and shared divider. Depends on fcc_pkg, fcc_if, fcc_div and fcc_store.
//
// The engine holds the first FAT copy in a byte store and serves one input
// beat at a time, giving one result beat for each. After reset and after every
// configuration write it runs a geometry pass (a 32-step division on the shared
// divider for the root directory sectors, then a second for the cluster count
// when the total sectors exceed the first data sector) before it takes the next
// input beat. A byte write goes straight to the store; following a cluster
// checks its range, reads the entry bytes and evaluates the entry, and a
// free-cluster scan does the same for every entry from cluster 2 on until it
// finds a free one or runs off the end of the stored FAT. The single read
// port of the byte store gives one byte per cycle. The store is not
// cleared: entries must be written before they are read.
module fat_cluster_chain_engine_top #(
  parameter int unsigned FAT_STORE_BYTES = fcc_pkg::FAT_STORE_BYTES_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  fcc_cfg_if.sink      cfg_i,
  fcc_in_if.sink       in_i,
  fcc_out_if.source    out_o
);
  import fcc_pkg::*;

  localparam int unsigned AW = $clog2(FAT_STORE_BYTES);
  localparam int unsigned LW = $clog2(FAT_STORE_BYTES + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_G1   = 8'b0000_0010,
    S_G2S  = 8'b0000_0100,
    S_G2   = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_EVAL = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  // Configuration registers.
  logic [12:0] bps_q;
  logic [7:0]  spc_q;
  logic [15:0] rs_q;
  logic [2:0]  nf_q;
  logic [23:0] spf_q;
  logic [15:0] rde_q;
  logic [31:0] ts_q;
  logic [27:0] rc_q;
  logic        dirty_q;
  logic        cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= BPS_RST;
      spc_q <= SPC_RST;
      rs_q  <= RS_RST;
      nf_q  <= NF_RST;
      spf_q <= SPF_RST;
      rde_q <= RDE_RST;
      ts_q  <= TS_RST;
      rc_q  <= RC_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_i.index))
        REG_BYTES_PER_SECTOR:    bps_q <= cfg_i.data[12:0];
        REG_SECTORS_PER_CLUSTER: spc_q <= cfg_i.data[7:0];
        REG_RESERVED_SECTORS:    rs_q  <= cfg_i.data[15:0];
        REG_NUMBER_OF_FATS:      nf_q  <= cfg_i.data[2:0];
        REG_SECTORS_PER_FAT:     spf_q <= cfg_i.data[23:0];
        REG_ROOT_DIR_ENTRIES:    rde_q <= cfg_i.data[15:0];
        REG_TOTAL_SECTORS:       ts_q  <= cfg_i.data[31:0];
        REG_ROOT_CLUSTER:        rc_q  <= cfg_i.data[27:0];
      endcase
    end
  end

  // A zero divisor counts as one.
  logic [12:0] bps1;
  logic [7:0]  spc1;
  assign bps1 = (bps_q == 13'd0) ? 13'd1 : bps_q;
  assign spc1 = (spc_q == 8'd0) ? 8'd1 : spc_q;

  // Sequencer and datapath registers.
  state_e      state_q, state_d;
  logic        dirty_d;
  logic [27:0] start_q, start_d;
  fat_type_e   type_q, type_d;
  logic [LW-1:0] limit_q, limit_d;
  mode_e       mode_q, mode_d;
  logic [27:0] c_q, c_d;
  logic [31:0] off_q, off_d;
  logic [2:0]  nb_q, nb_d;
  logic [2:0]  iss_q, iss_d;
  logic [2:0]  cap_q, cap_d;
  logic        pend_q;
  logic [31:0] word_q, word_d;
  logic [31:0] rnext_q, rnext_d;
  logic [31:0] rsec_q, rsec_d;
  logic        reoc_q, reoc_d;
  logic [27:0] rfree_q, rfree_d;
  logic        rstat_q, rstat_d;

  logic        out_valid_q;
  logic [31:0] out_next_q, out_sec_q;
  logic        out_eoc_q, out_stat_q;
  logic [27:0] out_free_q;
  fat_type_e   out_type_q;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        in_acc;
  logic        slot_free;
  logic        load_out;
  logic        mem_we, mem_re;
  logic [7:0]  mem_rdata;
  logic [31:0] off_calc;
  logic [2:0]  nb_calc;
  logic        in_rng;
  logic [31:0] entry;
  logic [31:0] thr;
  logic [35:0] sec_prod;
  logic [36:0] fat_span;
  logic        ts_above;

  assign in_i.ready = (state_q == S_IDLE) && !dirty_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign load_out   = (state_q == S_DONE) && slot_free;
  assign ts_above   = ts_q > {4'd0, start_q};

  // Entry offset, size and range check for the current cluster.
  always_comb begin
    unique case (type_q)
      FAT12: begin
        off_calc = {4'd0, c_q} + {5'd0, c_q[27:1]};
        nb_calc  = 3'd2;
      end
      FAT16: begin
        off_calc = {3'd0, c_q, 1'b0};
        nb_calc  = 3'd2;
      end
      default: begin
        off_calc = {2'd0, c_q, 2'b00};
        nb_calc  = 3'd4;
      end
    endcase
    in_rng = (c_q >= 28'd2) &&
             ((off_calc + 32'(nb_calc) - 32'd1) < 32'(limit_q));
  end

  // Entry value and end-of-chain threshold from the gathered bytes.
  always_comb begin
    unique case (type_q)
      FAT12: begin
        entry = c_q[0] ? {20'd0, word_q[15:4]} : (word_q & FAT12_ENTRY_MASK);
        thr   = EOC_FAT12;
      end
      FAT16: begin
        entry = {16'd0, word_q[15:0]};
        thr   = EOC_FAT16;
      end
      default: begin
        entry = {4'd0, word_q[27:0]};
        thr   = EOC_FAT32;
      end
    endcase
  end

  assign sec_prod = 36'(c_q - 28'd2) * 36'(spc1);
  assign fat_span = 37'(spf_q) * 37'(bps1);

  // Divider requests: root directory sectors, then the cluster count.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = 32'(22'(rde_q) * 22'(DIR_ENTRY_BYTES)) + 32'(bps1) - 32'd1;
    div_req.den   = 32'(bps1);
    if (state_q == S_IDLE && dirty_q) begin
      div_req.start = 1'b1;
    end else if (state_q == S_G2S) begin
      div_req.start = ts_above;
      div_req.num   = ts_q - {4'd0, start_q};
      div_req.den   = 32'(spc1);
    end
  end

  // Main sequencer.
  always_comb begin
    state_d = state_q;
    dirty_d = dirty_q;
    start_d = start_q;
    type_d  = type_q;
    limit_d = limit_q;
    mode_d  = mode_q;
    c_d     = c_q;
    off_d   = off_q;
    nb_d    = nb_q;
    iss_d   = iss_q;
    cap_d   = cap_q;
    word_d  = word_q;
    rnext_d = rnext_q;
    rsec_d  = rsec_q;
    reoc_d  = reoc_q;
    rfree_d = rfree_q;
    rstat_d = rstat_q;
    mem_re  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (dirty_q) begin
          dirty_d = 1'b0;
          state_d = S_G1;
        end else if (in_acc) begin
          mode_d  = mode_e'(in_i.mode);
          rnext_d = '0;
          rsec_d  = '0;
          reoc_d  = 1'b0;
          rfree_d = '0;
          rstat_d = 1'b0;
          unique case (mode_e'(in_i.mode))
            MODE_FOLLOW: begin
              c_d     = in_i.cluster;
              state_d = S_CHK;
            end
            MODE_SCAN: begin
              c_d     = 28'd2;
              state_d = S_CHK;
            end
            MODE_WRITE, MODE_NONE: state_d = S_DONE;
          endcase
        end
      end
      S_G1: begin
        if (div_rsp.done) begin
          start_d = 28'(rs_q) + 28'(27'(nf_q) * 27'(spf_q)) + div_rsp.quot[27:0];
          state_d = S_G2S;
        end
      end
      S_G2S: begin
        limit_d = (fat_span < 37'(FAT_STORE_BYTES)) ? LW'(fat_span)
                                                    : LW'(FAT_STORE_BYTES);
        if (ts_above) begin
          state_d = S_G2;
        end else begin
          type_d  = FAT12;
          state_d = S_IDLE;
        end
      end
      S_G2: begin
        if (div_rsp.done) begin
          if (div_rsp.quot < FAT12_MAX_CLUSTERS) begin
            type_d = FAT12;
          end else if (div_rsp.quot < FAT16_MAX_CLUSTERS) begin
            type_d = FAT16;
          end else begin
            type_d = FAT32;
          end
          state_d = S_IDLE;
        end
      end
      S_CHK: begin
        if (!in_rng) begin
          rstat_d = (mode_q == MODE_FOLLOW);
          state_d = S_DONE;
        end else begin
          off_d   = off_calc;
          nb_d    = nb_calc;
          iss_d   = '0;
          cap_d   = '0;
          word_d  = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        // Issue one byte address a cycle, collect each byte in the cycle after its address.
        if (iss_q < nb_q) begin
          mem_re = 1'b1;
          iss_d  = iss_q + 3'd1;
        end
        if (pend_q) begin
          word_d[{cap_q[1:0], 3'b000} +: 8] = mem_rdata;
          cap_d = cap_q + 3'd1;
          if (cap_q == nb_q - 3'd1) begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (mode_q == MODE_FOLLOW) begin
          rnext_d = entry;
          rsec_d  = {4'd0, start_q} + sec_prod[31:0];
          reoc_d  = entry >= thr;
          state_d = S_DONE;
        end else if (entry == 32'd0 && !(type_q == FAT32 && c_q == rc_q)) begin
          rfree_d = c_q;
          state_d = S_DONE;
        end else begin
          c_d     = c_q + 28'd1;
          state_d = S_CHK;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_wr) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dirty_q     <= 1'b1;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      type_q      <= FAT12;
      start_q     <= '0;
      limit_q     <= '0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
      pend_q  <= mem_re;
      type_q  <= type_d;
      start_q <= start_d;
      limit_q <= limit_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    c_q     <= c_d;
    off_q   <= off_d;
    nb_q    <= nb_d;
    iss_q   <= iss_d;
    cap_q   <= cap_d;
    word_q  <= word_d;
    rnext_q <= rnext_d;
    rsec_q  <= rsec_d;
    reoc_q  <= reoc_d;
    rfree_q <= rfree_d;
    rstat_q <= rstat_d;
  end

  // Output register, loaded when the finished beat finds the slot free.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_next_q <= rnext_q;
      out_sec_q  <= rsec_q;
      out_eoc_q  <= reoc_q;
      out_free_q <= rfree_q;
      out_stat_q <= rstat_q;
      out_type_q <= type_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.next_cluster   = out_next_q;
  assign out_o.cluster_sector = out_sec_q;
  assign out_o.end_of_chain   = out_eoc_q;
  assign out_o.free_cluster   = out_free_q;
  assign out_o.fat_type       = out_type_q;
  assign out_o.status         = out_stat_q;

  // Byte writes go straight to the store; writes beyond it are dropped.
  assign mem_we = in_acc && (mode_e'(in_i.mode) == MODE_WRITE) &&
                  (32'(in_i.fat_address) < 32'(FAT_STORE_BYTES));

  fcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fcc_store #(
    .DEPTH (FAT_STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(32'(in_i.fat_address))),
    .wdata_i (in_i.fat_byte),
    .re_i    (mem_re),
    .raddr_i (AW'(off_q + 32'(iss_q))),
    .rdata_o (mem_rdata)
  );

  // An input beat is taken only with the geometry up to date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !dirty_q && state_q == S_IDLE)
    else $error("input beat accepted with stale geometry");

  // The divider is started only from the geometry steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == S_IDLE || state_q == S_G2S))
    else $error("divider started outside the geometry pass");

  // A finished beat shows up on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_o.valid && state_q == S_IDLE)
    else $error("finished beat not presented");

  // Never more bytes collected than the entry holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> cap_q < nb_q && iss_q <= nb_q)
    else $error("byte gather overran the entry");

endmodule
